FILE: rtl/lfu_pkg.sv
// shared constants and types of the lfu cache
`default_nettype none
package lfu_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = 32;
	localparam int STAMP_BITS = 48;
	localparam int PORT_BITS  = 32;
	localparam int CAP_W      = 5;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic ACT_GET    = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} lfu_state_t;

	// search word passed from cell to cell
	typedef struct packed {
		logic                  valid;
		logic                  action;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		logic                  found;
		logic [IDX_W-1:0]      found_idx;
		logic [VALUE_BITS-1:0] found_value;
		logic                  best_valid;
		logic [IDX_W-1:0]      best_idx;
		logic [COUNT_BITS-1:0] best_count;
		logic [STAMP_BITS-1:0] best_stamp;
		logic [KEY_BITS-1:0]   best_key;
		logic [VALUE_BITS-1:0] best_value;
		logic                  free_valid;
		logic [IDX_W-1:0]      free_idx;
		logic [CNT_W-1:0]      used;
	} lfu_token_t;

	// update broadcast to all cells
	typedef struct packed {
		logic                  wr;
		logic                  fill;
		logic [IDX_W-1:0]      idx;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		logic [STAMP_BITS-1:0] stamp;
	} lfu_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/lfu_cell.sv
// one cache entry with its stage of the search chain
`default_nettype none
module lfu_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [lfu_pkg::IDX_W-1:0] idx,
	input  wire lfu_pkg::lfu_token_t       tok_in,
	output lfu_pkg::lfu_token_t            tok_out,
	input  wire lfu_pkg::lfu_cmd_t         cmd
);

	logic                           valid_q;
	logic [lfu_pkg::KEY_BITS-1:0]   key_q;
	logic [lfu_pkg::VALUE_BITS-1:0] value_q;
	logic [lfu_pkg::COUNT_BITS-1:0] count_q;
	logic [lfu_pkg::STAMP_BITS-1:0] stamp_q;

	lfu_pkg::lfu_token_t tok_next;
	lfu_pkg::lfu_token_t tok_s1;
	logic                vld_s1;
	logic                better;
	logic                sel;

	assign sel = cmd.wr && (cmd.idx == idx);

	always_comb begin
		better = !tok_in.best_valid || (count_q < tok_in.best_count) ||
			((count_q == tok_in.best_count) && (stamp_q < tok_in.best_stamp));
		tok_next = tok_in;
		if (valid_q) begin
			tok_next.used = tok_in.used + lfu_pkg::CNT_W'(1);
			if (!tok_in.found && (key_q == tok_in.key)) begin
				tok_next.found       = 1'b1;
				tok_next.found_idx   = idx;
				tok_next.found_value = value_q;
			end
			if (better) begin
				tok_next.best_valid = 1'b1;
				tok_next.best_idx   = idx;
				tok_next.best_count = count_q;
				tok_next.best_stamp = stamp_q;
				tok_next.best_key   = key_q;
				tok_next.best_value = value_q;
			end
		end else if (!tok_in.free_valid) begin
			tok_next.free_valid = 1'b1;
			tok_next.free_idx   = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_s1 <= tok_next;
	end

	always_comb begin
		tok_out       = tok_s1;
		tok_out.valid = vld_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel && cmd.fill) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			stamp_q <= cmd.stamp;
			if (cmd.fill) begin
				key_q   <= cmd.key;
				value_q <= cmd.value;
				count_q <= lfu_pkg::COUNT_BITS'(1);
			end else if (count_q != '1) begin
				count_q <= count_q + lfu_pkg::COUNT_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/lfu_ctrl.sv
// sequencer: launches searches, decides hit or eviction, holds the result
`default_nettype none
module lfu_ctrl (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             action,
	input  wire logic [lfu_pkg::PORT_BITS-1:0]    key,
	input  wire logic [lfu_pkg::PORT_BITS-1:0]    value,
	input  wire logic                             cfg_we,
	input  wire logic [lfu_pkg::CAP_W-1:0]        cfg_wdata,
	output lfu_pkg::lfu_token_t                   tok_head,
	input  wire lfu_pkg::lfu_token_t              tok_tail,
	output lfu_pkg::lfu_cmd_t                     cmd,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  hit,
	output logic [lfu_pkg::PORT_BITS-1:0]         read_value,
	output logic                                  evicted,
	output logic [lfu_pkg::PORT_BITS-1:0]         evicted_key,
	output logic [lfu_pkg::PORT_BITS-1:0]         evicted_value
);

	lfu_pkg::lfu_state_t state_q, state_d;

	logic [lfu_pkg::CAP_W-1:0]      capacity_q;
	logic [lfu_pkg::STAMP_BITS-1:0] stamp_q;
	lfu_pkg::lfu_token_t            tok_q;
	logic                           out_valid_q;
	logic                           commit;

	logic [lfu_pkg::CMP_W-1:0] cap_ext, cap_eff, used_ext;

	logic                            hit_d, ev_d;
	logic [lfu_pkg::VALUE_BITS-1:0]  rv_d, evv_d;
	logic [lfu_pkg::KEY_BITS-1:0]    ek_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lfu_pkg::ST_IDLE:   if (in_valid) state_d = lfu_pkg::ST_SCAN;
			lfu_pkg::ST_SCAN:   if (tok_tail.valid) state_d = lfu_pkg::ST_COMMIT;
			lfu_pkg::ST_COMMIT: if (!out_valid_q || out_ready) state_d = lfu_pkg::ST_IDLE;
			default:            state_d = lfu_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = (state_q == lfu_pkg::ST_IDLE);
		commit   = (state_q == lfu_pkg::ST_COMMIT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lfu_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// empty search word for the head of the chain
	always_comb begin
		tok_head        = '0;
		tok_head.valid  = in_valid && in_ready;
		tok_head.action = action;
		tok_head.key    = lfu_pkg::KEY_BITS'(key);
		tok_head.value  = lfu_pkg::VALUE_BITS'(value);
	end

	always_ff @(posedge clk) begin
		if (state_q == lfu_pkg::ST_SCAN && tok_tail.valid) begin
			tok_q <= tok_tail;
		end
	end

	// capacity clamped to one .. ENTRIES
	always_comb begin
		cap_ext  = lfu_pkg::CMP_W'(capacity_q);
		used_ext = lfu_pkg::CMP_W'(tok_q.used);
		if (cap_ext == '0) begin
			cap_eff = lfu_pkg::CMP_W'(1);
		end else if (cap_ext > lfu_pkg::CMP_W'(lfu_pkg::ENTRIES)) begin
			cap_eff = lfu_pkg::CMP_W'(lfu_pkg::ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end

	// decision on the finished search
	always_comb begin
		hit_d     = 1'b0;
		rv_d      = '0;
		ev_d      = 1'b0;
		ek_d      = '0;
		evv_d     = '0;
		cmd       = '0;
		cmd.key   = tok_q.key;
		cmd.value = tok_q.value;
		cmd.stamp = stamp_q;
		if (tok_q.action == lfu_pkg::ACT_GET) begin
			if (tok_q.found) begin
				hit_d   = 1'b1;
				rv_d    = tok_q.found_value;
				cmd.wr  = commit;
				cmd.idx = tok_q.found_idx;
			end
		end else if (tok_q.found) begin
			// key already present: left untouched
			hit_d = 1'b1;
		end else if ((used_ext >= cap_eff) && tok_q.best_valid) begin
			ev_d     = 1'b1;
			ek_d     = tok_q.best_key;
			evv_d    = tok_q.best_value;
			cmd.wr   = commit;
			cmd.fill = 1'b1;
			cmd.idx  = tok_q.best_idx;
		end else if (tok_q.free_valid) begin
			cmd.wr   = commit;
			cmd.fill = 1'b1;
			cmd.idx  = tok_q.free_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q <= '0;
		end else if (cmd.wr) begin
			stamp_q <= stamp_q + lfu_pkg::STAMP_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit           <= hit_d;
			read_value    <= lfu_pkg::PORT_BITS'(rv_d);
			evicted       <= ev_d;
			evicted_key   <= lfu_pkg::PORT_BITS'(ek_d);
			evicted_value <= lfu_pkg::PORT_BITS'(evv_d);
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/lfu_cache_lookup_insert.sv
// top level of the lfu cache: chain of entry cells and the sequencer
// a word is accepted only while idle; it walks the chain of cell registers, is held
// by the sequencer and, once the result slot is free, commits into the registered
//   result word; no new word is taken until that commit is done
// reset: all entries empty, stamp counter zero, capacity 16, no result pending
`default_nettype none
module lfu_cache_lookup_insert (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          action,
	input  wire logic [lfu_pkg::PORT_BITS-1:0] key,
	input  wire logic [lfu_pkg::PORT_BITS-1:0] value,
	input  wire logic                          cfg_we,
	input  wire logic [lfu_pkg::CAP_W-1:0]     cfg_wdata,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               hit,
	output logic [lfu_pkg::PORT_BITS-1:0]      read_value,
	output logic                               evicted,
	output logic [lfu_pkg::PORT_BITS-1:0]      evicted_key,
	output logic [lfu_pkg::PORT_BITS-1:0]      evicted_value
);

	// search word links: link i feeds cell i, the last link goes back to the sequencer
	lfu_pkg::lfu_token_t tok_chain [lfu_pkg::ENTRIES+1];
	lfu_pkg::lfu_cmd_t   cmd;

	// one valid flag per stage, for checking that a single search is in flight
	logic [lfu_pkg::ENTRIES-1:0] tok_vld;

	lfu_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.key           (key),
		.value         (value),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.tok_head      (tok_chain[0]),
		.tok_tail      (tok_chain[lfu_pkg::ENTRIES]),
		.cmd           (cmd),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.read_value    (read_value),
		.evicted       (evicted),
		.evicted_key   (evicted_key),
		.evicted_value (evicted_value)
	);

	// each cell checks its own entry against the passing word: key match,
	// running victim (lowest count, then oldest stamp), first free slot, use count
	for (genvar i = 0; i < lfu_pkg::ENTRIES; i++) begin : g_cell
		lfu_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (lfu_pkg::IDX_W'(i)),
			.tok_in  (tok_chain[i]),
			.tok_out (tok_chain[i+1]),
			.cmd     (cmd)
		);
		assign tok_vld[i] = tok_chain[i+1].valid;
	end

	// busy as soon as a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again while a search is running");

	// never more than one search word in the chain
	a_single_search: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one search word in the cell chain");

	// at most one entry update per word
	a_single_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |=> !cmd.wr)
		else $error("entry update repeated on consecutive cycles");

	// no search in flight while an update is broadcast
	a_update_quiet_chain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (tok_vld == '0))
		else $error("entry updated while a search is walking the chain");

endmodule
`default_nettype wire

FILE: dv/lfu_cache_mirror_pkg.sv
// expected-reply mirror of the lfu cache, with its reply queue and checker
package lfu_cache_mirror_pkg;

	import lfu_pkg::*;

	typedef struct packed {
		logic                 hit;
		logic [PORT_BITS-1:0] read_value;
		logic                 evicted;
		logic [PORT_BITS-1:0] evicted_key;
		logic [PORT_BITS-1:0] evicted_value;
	} cache_reply_t;

	class lfu_mirror;
		bit                    entry_used  [ENTRIES];
		logic [KEY_BITS-1:0]   entry_key   [ENTRIES];
		logic [VALUE_BITS-1:0] entry_value [ENTRIES];
		logic [COUNT_BITS-1:0] entry_count [ENTRIES];
		logic [STAMP_BITS-1:0] entry_stamp [ENTRIES];
		logic [STAMP_BITS-1:0] stamp_next;
		logic [CAP_W-1:0]      capacity;
		cache_reply_t          pending_replies[$];
		int unsigned           mismatches;

		function new();
			foreach (entry_used[i]) begin
				entry_used[i] = 1'b0;
			end
			stamp_next = '0;
			capacity   = CAP_RESET;
			mismatches = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] cap);
			capacity = cap;
		endfunction

		// works out the reply to one accepted word and moves the mirror on
		function void predict_word(logic act, logic [PORT_BITS-1:0] k,
				logic [PORT_BITS-1:0] v);
			cache_reply_t r;
			int           cap_eff;
			int           slot;
			int           used;
			int           victim;
			r       = '0;
			cap_eff = capacity;
			if (cap_eff < 1) begin
				cap_eff = 1;
			end
			if (cap_eff > ENTRIES) begin
				cap_eff = ENTRIES;
			end
			slot = -1;
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot < 0 && entry_used[i] && entry_key[i] == k) begin
					slot = i;
				end
			end
			if (act == ACT_GET) begin
				if (slot >= 0) begin
					r.hit        = 1'b1;
					r.read_value = entry_value[slot];
					if (entry_count[slot] != '1) begin
						entry_count[slot]++;
					end
					entry_stamp[slot] = stamp_next;
					stamp_next++;
				end
			end else if (slot >= 0) begin
				// key already held: left untouched
				r.hit = 1'b1;
			end else begin
				used = 0;
				foreach (entry_used[i]) begin
					used += entry_used[i];
				end
				if (used >= cap_eff) begin
					victim = -1;
					for (int i = 0; i < ENTRIES; i++) begin
						if (entry_used[i] && (victim < 0 ||
								entry_count[i] < entry_count[victim] ||
								(entry_count[i] == entry_count[victim] &&
								 entry_stamp[i] < entry_stamp[victim]))) begin
							victim = i;
						end
					end
					if (victim >= 0) begin
						r.evicted          = 1'b1;
						r.evicted_key      = entry_key[victim];
						r.evicted_value    = entry_value[victim];
						entry_used[victim] = 1'b0;
						slot               = victim;
					end
				end
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot < 0 && !entry_used[i]) begin
						slot = i;
					end
				end
				if (slot >= 0) begin
					entry_used[slot]  = 1'b1;
					entry_key[slot]   = k;
					entry_value[slot] = v;
					entry_count[slot] = 1;
					entry_stamp[slot] = stamp_next;
					stamp_next++;
				end
			end
			pending_replies.push_back(r);
		endfunction

		function void note_mismatch(string what, cache_reply_t exp_r, cache_reply_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch %0d (%s): expected hit %0b rd %h ev %0b ek %h evv %h",
					mismatches, what, exp_r.hit, exp_r.read_value, exp_r.evicted,
					exp_r.evicted_key, exp_r.evicted_value);
				$display("    got hit %0b rd %h ev %0b ek %h evv %h", got.hit,
					got.read_value, got.evicted, got.evicted_key, got.evicted_value);
			end
		endfunction

		function void check_word(cache_reply_t got);
			cache_reply_t exp_r;
			if (pending_replies.size() == 0) begin
				note_mismatch("reply with none pending", '0, got);
			end else begin
				exp_r = pending_replies.pop_front();
				if (got.hit !== exp_r.hit || got.read_value !== exp_r.read_value ||
						got.evicted !== exp_r.evicted ||
						got.evicted_key !== exp_r.evicted_key ||
						got.evicted_value !== exp_r.evicted_value) begin
					note_mismatch("field", exp_r, got);
				end
			end
		endfunction
	endclass

endpackage

FILE: dv/lfu_cache_lookup_insert_tb.sv
// testbench of the lfu cache: directed and random lookups and inserts under several capacities
module lfu_cache_lookup_insert_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import lfu_pkg::*;
	import lfu_cache_mirror_pkg::*;

	localparam int POOL_SIZE = 24;
	// accepted word to reply word, plus slack
	localparam int SETTLE_CYCLES = ENTRIES + 2 + 8;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 action;
	logic [PORT_BITS-1:0] key;
	logic [PORT_BITS-1:0] value;
	logic                 cfg_we;
	logic [CAP_W-1:0]     cfg_wdata;
	logic                 out_valid;
	logic                 out_ready;
	logic                 hit;
	logic [PORT_BITS-1:0] read_value;
	logic                 evicted;
	logic [PORT_BITS-1:0] evicted_key;
	logic [PORT_BITS-1:0] evicted_value;

	lfu_mirror mirror = new();

	// keys that the random phases keep coming back to, so that lookups hit
	logic [PORT_BITS-1:0] key_pool[POOL_SIZE];
	// per-phase switches for stretches with no idling on either side
	bit sender_steady   = 1'b0;
	bit receiver_steady = 1'b0;

	lfu_cache_lookup_insert dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.key          (key),
		.value        (value),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.read_value   (read_value),
		.evicted      (evicted),
		.evicted_key  (evicted_key),
		.evicted_value(evicted_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// offers one word after a random gap and returns at the edge that takes it;
	// valid stays high on return so a back-to-back word follows without a dip
	task automatic send_word(input logic act, input logic [PORT_BITS-1:0] k,
			input logic [PORT_BITS-1:0] v);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		key      <= k;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		mirror.predict_word(act, k, v);
	endtask

	// holds the sender off until every pending reply has been taken
	task automatic drain_replies();
		in_valid <= 1'b0;
		while (mirror.pending_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// capacity only changes while the cache is idle
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		drain_replies();
		cfg_wdata <= cap;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mirror.set_capacity(cap);
	endtask

	function automatic logic [PORT_BITS-1:0] fresh_key();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			return '0;
		end else if (roll == 1) begin
			return '1;
		end
		return $urandom;
	endfunction

	// edge cases first: miss on empty, extreme keys and values, re-insert of a
	// held key, capacity below the entries in use, zero capacity, and a tie on
	// count broken by the older stamp
	task automatic run_directed();
		send_word(ACT_GET,    32'h0000_0000, 32'h1111_1111);
		send_word(ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_word(ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_word(ACT_GET,    32'h0000_0000, 32'h0);
		send_word(ACT_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(ACT_INSERT, 32'h0000_0000, 32'h1234_5678);
		send_word(ACT_GET,    32'h0000_0000, 32'h0);
		send_word(ACT_GET,    32'h5A5A_5A5A, 32'h0);
		// one slot allowed with two held: each insert evicts just one
		write_capacity(CAP_W'(1));
		send_word(ACT_INSERT, 32'hA5A5_A5A5, 32'h0000_0001);
		send_word(ACT_INSERT, 32'h3C3C_3C3C, 32'h8000_0000);
		send_word(ACT_GET,    32'hFFFF_FFFF, 32'h0);
		// zero capacity acts as one
		write_capacity(CAP_W'(0));
		send_word(ACT_GET,    32'h0000_0000, 32'h0);
		send_word(ACT_INSERT, 32'h0000_0001, 32'h7FFF_FFFF);
		send_word(ACT_GET,    32'h0000_0001, 32'h0);
		send_word(ACT_GET,    32'h0000_0001, 32'h0);
		send_word(ACT_GET,    32'h0000_0001, 32'h0);
		// counts now equal: the older of the two goes
		send_word(ACT_INSERT, 32'h0000_0002, 32'hC3C3_C3C3);
		send_word(ACT_GET,    32'h0000_0000, 32'h0);
		send_word(ACT_GET,    32'h0000_0002, 32'h0);
	endtask

	// random words over a skewed key pool so counts spread out and evictions bite
	task automatic run_phase(input logic [CAP_W-1:0] cap, input int words);
		int cap_eff;
		int pool_n;
		int pick;
		int roll;
		write_capacity(cap);
		cap_eff = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : int'(cap));
		pool_n  = cap_eff + $urandom_range(1, 6);
		if (pool_n > POOL_SIZE) begin
			pool_n = POOL_SIZE;
		end
		// keep about half the old keys so held entries stay reachable
		foreach (key_pool[i]) begin
			if ($urandom_range(0, 1) == 0) begin
				key_pool[i] = fresh_key();
			end
		end
		sender_steady   = ($urandom_range(0, 3) == 0);
		receiver_steady = ($urandom_range(0, 3) == 0);
		for (int n = 0; n < words; n++) begin
			roll = $urandom_range(0, 99);
			pick = $urandom_range(0, $urandom_range(0, pool_n - 1));
			if (roll < 45) begin
				send_word(ACT_GET, key_pool[pick], $urandom);
			end else if (roll < 85) begin
				send_word(ACT_INSERT, key_pool[pick], $urandom);
			end else if (roll < 95) begin
				send_word(ACT_GET, fresh_key(), $urandom);
			end else begin
				send_word(ACT_INSERT, fresh_key(), $urandom);
			end
			if ($urandom_range(0, 99) == 0) begin
				drain_replies();
			end
		end
	endtask

	// receiver: random stall before each reply word, checked at the edge that takes it
	initial begin
		cache_reply_t got;
		int           stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = receiver_steady ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.hit           = hit;
			got.read_value    = read_value;
			got.evicted       = evicted;
			got.evicted_key   = evicted_key;
			got.evicted_value = evicted_value;
			mirror.check_word(got);
		end
	end

	// stimulus and end of run
	initial begin
		logic [CAP_W-1:0] phase_caps[11];
		int               waited;
		phase_caps = '{CAP_W'(16), CAP_W'(3), CAP_W'(31), CAP_W'(0), CAP_W'(1),
			CAP_W'(8), CAP_W'(16), CAP_W'(2), CAP_W'(12), CAP_W'(5), CAP_W'(16)};
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		action    <= ACT_GET;
		key       <= '0;
		value     <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		foreach (key_pool[i]) begin
			key_pool[i] = fresh_key();
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		// the first random phase allows all sixteen, the next drops to three
		foreach (phase_caps[p]) begin
			run_phase(phase_caps[p], 64);
		end
		in_valid <= 1'b0;
		waited = 0;
		while (mirror.pending_replies.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0) begin
			$display("lfu_cache_lookup_insert_tb: done, clean");
		end else begin
			$display("lfu_cache_lookup_insert_tb: done, errors");
		end
		$finish;
	end

	// watchdog, several times the slowest clean run
	initial begin
		#400_000;
		$display("lfu_cache_lookup_insert_tb: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
rtl/lfu_pkg.sv
rtl/lfu_cell.sv
rtl/lfu_ctrl.sv
rtl/lfu_cache_lookup_insert.sv
dv/lfu_cache_mirror_pkg.sv
dv/lfu_cache_lookup_insert_tb.sv
